### design/ate_pkg.sv
// Shared types, constants and helper functions for the time-string converter.
package ate_pkg;

    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int DAYS_PER_YEAR = 365;
    localparam int MAX_MONTH     = 12;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MINUTE    = 59;
    localparam int CENTURY       = 100;
    localparam int GT_BASE_YEAR  = 1970;
    localparam int UT_PIVOT_YEAR = 70;
    localparam int UT_WRAP_ADD   = 30;
    localparam int DIV100_MUL    = 5243;
    localparam int DIV100_SHIFT  = 19;
    localparam int POS_MAX       = 63;
    localparam int ZONE_LEN      = 4;
    localparam int UT_DATE_LEN   = 10;
    localparam int GT_DATE_LEN   = 12;
    localparam int UT_YEAR_LEN   = 2;
    localparam int GT_YEAR_LEN   = 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        PH_DATE = 2'd0,
        PH_FRAC = 2'd1,
        PH_ZONE = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ZS_NONE  = 2'd0,
        ZS_PLUS  = 2'd1,
        ZS_MINUS = 2'd2,
        ZS_RSVD  = 2'd3
    } t_zsign;

    // One finished string, handed from front to back
    typedef struct packed {
        logic        kind;
        logic        err;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        t_zsign      zsign;
        logic [13:0] zone;
    } t_rec;

    function automatic logic [8:0] ate_month_start(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            4'd12:   v = 9'd365;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [13:0] ate_mul10_14(input logic [13:0] x, input logic [3:0] d);
        return (x << 3) + (x << 1) + {10'd0, d};
    endfunction

    function automatic logic [6:0] ate_mul10_7(input logic [6:0] x, input logic [3:0] d);
        return (x << 3) + (x << 1) + {3'd0, d};
    endfunction

endpackage

### design/ate_front.sv
// Front end: accepts characters, accumulates digit fields, emits one record per string.
module ate_front import ate_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_time_kind,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_char,
    output logic       o_push,
    output t_rec       o_rec
);

    logic [5:0]  r_pos,    n_pos;
    t_phase      r_phase,  n_phase;
    logic [13:0] r_year,   n_year;
    logic [6:0]  r_month,  n_month;
    logic [6:0]  r_day,    n_day;
    logic [6:0]  r_hour,   n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;
    t_zsign      r_zsign,  n_zsign;
    logic [13:0] r_zone,   n_zone;
    logic        r_err,    n_err;

    logic       dig;
    logic [3:0] dval;
    logic [5:0] ylen;
    logic [5:0] dbase;
    logic [5:0] fpos;
    logic       allow_frac;
    logic       cnt_ok_cur;
    logic       cnt_ok_nxt;

    assign dig        = (i_char_byte >= CH_ZERO) && (i_char_byte <= CH_NINE);
    assign dval       = dig ? 4'(i_char_byte - CH_ZERO) : 4'd0;
    assign ylen       = i_time_kind ? 6'(GT_YEAR_LEN) : 6'(UT_YEAR_LEN);
    assign dbase      = i_time_kind ? 6'(GT_DATE_LEN) : 6'(UT_DATE_LEN);
    assign fpos       = r_pos - ylen;
    assign allow_frac = i_time_kind && (r_phase == PH_DATE);
    assign cnt_ok_cur = (r_pos == dbase) || (r_pos == dbase + 6'd2);
    assign cnt_ok_nxt = (n_pos == dbase) || (n_pos == dbase + 6'd2);

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_zsign  = r_zsign;
        n_zone   = r_zone;
        n_err    = r_err;
        case (r_phase)
            PH_DATE, PH_FRAC: begin
                if (dig) begin
                    if (r_phase == PH_DATE) begin
                        if (r_pos < ylen) begin
                            n_year = ate_mul10_14(r_year, dval);
                        end else if (fpos < 6'd2) begin
                            n_month = ate_mul10_7(r_month, dval);
                        end else if (fpos < 6'd4) begin
                            n_day = ate_mul10_7(r_day, dval);
                        end else if (fpos < 6'd6) begin
                            n_hour = ate_mul10_7(r_hour, dval);
                        end else if (fpos < 6'd8) begin
                            n_minute = ate_mul10_7(r_minute, dval);
                        end else if (fpos < 6'd10) begin
                            n_second = ate_mul10_7(r_second, dval);
                        end else begin
                            n_err = 1'b1;
                        end
                        if (r_pos != 6'(POS_MAX)) begin
                            n_pos = r_pos + 6'd1;
                        end
                    end
                end else begin
                    if (r_phase == PH_DATE && !cnt_ok_cur) begin
                        n_err = 1'b1;
                    end
                    if (i_char_byte == CH_Z) begin
                        n_phase = PH_DONE;
                    end else if (i_char_byte == CH_PLUS || i_char_byte == CH_MINUS) begin
                        n_zsign = (i_char_byte == CH_PLUS) ? ZS_PLUS : ZS_MINUS;
                        n_phase = PH_ZONE;
                        n_pos   = 6'd0;
                    end else if (allow_frac &&
                                 (i_char_byte == CH_DOT || i_char_byte == CH_COMMA)) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_ZONE: begin
                if (dig && r_pos < 6'(ZONE_LEN)) begin
                    n_zone = ate_mul10_14(r_zone, dval);
                    n_pos  = r_pos + 6'd1;
                end else begin
                    n_err = 1'b1;
                end
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    assign o_push = i_accept && i_last_char;

    always_comb begin
        o_rec.kind   = i_time_kind;
        o_rec.err    = n_err || (n_phase == PH_DATE && !cnt_ok_nxt) ||
                       (n_phase == PH_ZONE && n_pos != 6'(ZONE_LEN));
        o_rec.year   = n_year;
        o_rec.month  = n_month;
        o_rec.day    = n_day;
        o_rec.hour   = n_hour;
        o_rec.minute = n_minute;
        o_rec.second = n_second;
        o_rec.zsign  = n_zsign;
        o_rec.zone   = n_zone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos    <= '0;
            r_phase  <= PH_DATE;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_zsign  <= ZS_NONE;
            r_zone   <= '0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_zsign  <= n_zsign;
            r_zone   <= n_zone;
            r_err    <= n_err;
        end
    end

endmodule

### design/ate_queue.sv
// Two-entry record queue between front and back.
module ate_queue import ate_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_rec o_rec
);

    t_rec       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2 || i_pop))
        else $error("queue push while full");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

### design/ate_back.sv
// Back end: range checks and calendar conversion over a short sequence, output register.
module ate_back import ate_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_rec               i_q_rec,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [39:0] o_epoch_seconds,
    output logic               o_is_error
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_A    = 7'b0000010,
        S_B    = 7'b0000100,
        S_C    = 7'b0001000,
        S_D    = 7'b0010000,
        S_E    = 7'b0100000,
        S_F    = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    t_rec        r_rec;
    logic        r_err;
    logic [13:0] r_yr;
    logic [26:0] r_zprod;
    logic [7:0]  r_zq;
    logic [13:0] r_zm;
    logic [22:0] r_y365;
    logic [23:0] r_days;
    logic [13:0] r_zmin;
    logic [28:0] r_dh;
    logic [19:0] r_zoff;
    logic [39:0] r_prod;
    logic [11:0] r_ms;
    logic        r_out_valid;
    logic [39:0] r_out_val;
    logic        r_out_err;

    logic        out_free;
    logic        yr_low;
    logic [13:0] yr_a;
    logic        err_a;
    logic        mo_bad;
    logic [3:0]  mo_idx;
    logic [7:0]  zq_b;
    logic [13:0] zm_b;
    logic [14:0] yr2;
    logic        leap;
    logic [8:0]  dim;
    logic        err_b;
    logic [23:0] days_c;
    logic [39:0] val_f;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    // Stage A: year offset, field limits, zone divide-by-100 product
    assign yr_low = r_rec.kind ? (r_rec.year < 14'(GT_BASE_YEAR)) : 1'b0;
    always_comb begin
        if (r_rec.kind) begin
            yr_a = r_rec.year - 14'(GT_BASE_YEAR);
        end else if (r_rec.year >= 14'(UT_PIVOT_YEAR)) begin
            yr_a = r_rec.year - 14'(UT_PIVOT_YEAR);
        end else begin
            yr_a = r_rec.year + 14'(UT_WRAP_ADD);
        end
    end
    assign mo_bad = (r_rec.month < 7'd1) || (r_rec.month > 7'(MAX_MONTH));
    assign err_a  = r_rec.err || yr_low || mo_bad ||
                    (r_rec.hour > 7'(MAX_HOUR)) || (r_rec.minute > 7'(MAX_MINUTE)) ||
                    (r_rec.second > 7'(MAX_MINUTE));

    // Stage B: zone split, day-of-month limit
    assign mo_idx = mo_bad ? 4'd1 : r_rec.month[3:0];
    assign zq_b   = r_zprod[DIV100_SHIFT +: 8];
    assign zm_b   = r_rec.zone - ({6'd0, zq_b} * 14'(CENTURY));
    assign yr2    = {1'b0, r_yr} + 15'd2;
    assign leap   = (yr2[1:0] == 2'd0);
    assign dim    = ate_month_start(mo_idx) - ate_month_start(mo_idx - 4'd1) +
                    ((leap && mo_idx == 4'd2) ? 9'd1 : 9'd0);
    assign err_b  = (r_rec.day < 7'd1) || ({2'd0, r_rec.day} > dim) ||
                    (zq_b > 8'(MAX_HOUR)) || (zm_b > 14'(MAX_MINUTE));

    // Stage C: day count
    assign days_c = {1'b0, r_y365} + {15'd0, ate_month_start(mo_idx - 4'd1)} +
                    {11'd0, yr2[14:2]} + {17'd0, r_rec.day} -
                    ((leap && mo_idx < 4'd3) ? 24'd1 : 24'd0) - 24'd1;

    // Stage F: final sum with zone offset
    always_comb begin
        val_f = r_prod + {28'd0, r_ms};
        if (r_rec.zsign == ZS_PLUS) begin
            val_f = val_f - {20'd0, r_zoff};
        end else if (r_rec.zsign == ZS_MINUS) begin
            val_f = val_f + {20'd0, r_zoff};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_A;
            S_A:     n_state = S_B;
            S_B:     n_state = S_C;
            S_C:     n_state = S_D;
            S_D:     n_state = S_E;
            S_E:     n_state = S_F;
            S_F:     if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rec <= i_q_rec;
            end
            S_A: begin
                r_yr    <= yr_a;
                r_err   <= err_a;
                r_zprod <= {13'd0, r_rec.zone} * 27'(DIV100_MUL);
            end
            S_B: begin
                r_zq   <= zq_b;
                r_zm   <= zm_b;
                r_err  <= r_err || err_b;
                r_y365 <= {9'd0, r_yr} * 23'(DAYS_PER_YEAR);
            end
            S_C: begin
                r_days <= days_c;
                r_zmin <= ({6'd0, r_zq} * 14'(MIN_PER_HOUR)) + r_zm;
            end
            S_D: begin
                r_dh   <= ({5'd0, r_days} * 29'(HOURS_PER_DAY)) + {22'd0, r_rec.hour};
                r_zoff <= {6'd0, r_zmin} * 20'(SEC_PER_MIN);
            end
            S_E: begin
                r_prod <= {11'd0, r_dh} * 40'(SEC_PER_HOUR);
                r_ms   <= ({5'd0, r_rec.minute} * 12'(SEC_PER_MIN)) + {5'd0, r_rec.second};
            end
            default: begin
            end
        endcase
        if (r_state == S_F && out_free) begin
            r_out_val <= r_err ? 40'd0 : val_f;
            r_out_err <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_F && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_epoch_seconds = $signed(r_out_val);
    assign o_is_error      = r_out_err;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_val == 40'd0))
        else $error("error item carries nonzero seconds");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_A))
        else $error("pop did not start conversion");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished item not presented");
`endif

endmodule

### design/asn1_time_to_epoch_seconds.sv
// Top level: time-string characters in, seconds since 1970 out.
//
// Input channel: one character per item (i_char_byte) with its kind bit
// (0 two-digit year, 1 four-digit year) and a last-character mark. An item
// is accepted when i_in_valid is high and o_in_stall is low. The front end
// takes one character per cycle; o_in_stall rises only while the two-entry
// record queue to the back end is full.
// Output channel: one item per string, on its last character: signed 40-bit
// seconds with the zone offset applied, or o_is_error with zero seconds.
// An item is taken when o_out_valid is high and i_out_stall is low.
// A string's result passes through the record queue, the back end's
// conversion sequence (steps A to F) and the output register before
// o_out_valid rises. The back end converts one string at a time and pops
// the next record only from its idle state; the queue holds later strings.
// While the receiver stalls, the result holds in the output register, the
// back end waits in its last step, and the queue takes up to two more strings.
// Reset (synchronous, active low) clears the parse state, queue and output.
module asn1_time_to_epoch_seconds import ate_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_time_kind,
    input  logic [7:0]         i_char_byte,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [39:0] o_epoch_seconds,
    output logic               o_is_error
);

    logic accept;
    logic push;
    t_rec push_rec;
    logic q_full;
    logic q_valid;
    logic pop;
    t_rec q_rec;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    ate_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_time_kind (i_time_kind),
        .i_char_byte (i_char_byte),
        .i_last_char (i_last_char),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    ate_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    ate_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_rec         (q_rec),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_epoch_seconds (o_epoch_seconds),
        .o_is_error      (o_is_error)
    );

endmodule
